[hdl/pst_pkg.sv]
// Shared types and constants for the probe request client/SSID tracker.
package pst_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [3:0] SUBTYPE_PROBE = 4'h4;
  localparam logic [6:0] MIN_FRAME_LEN = 7'd26;
  localparam logic [7:0] MAX_SSID_LEN  = 8'd32;
  localparam logic [5:0] SSID_START    = 6'd26;
  localparam logic [5:0] CLIENT_START  = 6'd10;
  localparam logic [5:0] TAG_ID_POS    = 6'd24;
  localparam logic [5:0] TAG_LEN_POS   = 6'd25;
  localparam logic [5:0] POS_MAX       = 6'd63;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_DEL      = 8'h7F;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_NEW      = 3'd1,
    ST_EVICTED  = 3'd2,
    ST_NOT_MGMT = 3'd3,
    ST_SHORT    = 3'd4,
    ST_SUBTYPE  = 3'd5,
    ST_NO_SSID  = 3'd6,
    ST_BAD_CHAR = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_WRITE
  } back_state_t;

  // One judged frame handed from the front to the back.
  typedef struct packed {
    logic          accept;
    status_t       status;
    logic [47:0]   client;
    logic [255:0]  ssid;
    logic [5:0]    ssid_bytes;
    logic [7:0]    rssi;
    logic [31:0]   now_ms;
  } job_t;

endpackage

[hdl/pst_front.sv]
// Byte capture and frame classification front end.
module pst_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_first,
  input  logic          in_last,
  input  logic          in_mgmt,
  input  logic [7:0]    in_rssi,
  input  logic [31:0]   in_now,
  output pst_pkg::job_t job,
  output logic          job_push
);
  import pst_pkg::*;

  logic         reject_high_bytes;
  logic [5:0]   pos;
  logic [47:0]  client;
  logic [255:0] ssid;
  logic [7:0]   frame_ctrl;
  logic [7:0]   tag_id;
  logic [7:0]   tag_len;
  logic         bad;

  logic [5:0]   pos_cur;
  logic [47:0]  client_next;
  logic [255:0] ssid_next;
  logic [7:0]   frame_ctrl_next;
  logic [7:0]   tag_id_next;
  logic [7:0]   tag_len_next;
  logic         bad_next;
  logic [5:0]   k6;
  logic [4:0]   k;
  logic         bad_byte;
  logic [6:0]   frame_len;
  logic [8:0]   need_len;

  always_comb begin
    pos_cur         = in_first ? 6'd0 : pos;
    client_next     = (pos_cur == 6'd0) ? 48'd0 : client;
    ssid_next       = (pos_cur == 6'd0) ? 256'd0 : ssid;
    frame_ctrl_next = (pos_cur == 6'd0) ? 8'd0 : frame_ctrl;
    tag_id_next     = (pos_cur == 6'd0) ? 8'd0 : tag_id;
    tag_len_next    = (pos_cur == 6'd0) ? 8'd0 : tag_len;
    bad_next        = (pos_cur == 6'd0) ? 1'b0 : bad;
    k6       = pos_cur - SSID_START;
    k        = k6[4:0];
    bad_byte = (in_byte < CHAR_SPACE) || (in_byte == CHAR_DEL) ||
               (reject_high_bytes && in_byte[7]);
    if (pos_cur == 6'd0) begin
      frame_ctrl_next = in_byte;
    end
    for (int i = 0; i < 6; i++) begin
      if (pos_cur == CLIENT_START + 6'(i)) client_next[8*i +: 8] = in_byte;
    end
    if (pos_cur == TAG_ID_POS) tag_id_next = in_byte;
    if (pos_cur == TAG_LEN_POS) tag_len_next = in_byte;
    if (pos_cur >= SSID_START && pos_cur <= SSID_START + 6'd31 &&
        {3'd0, k} < tag_len_next) begin
      for (int i = 0; i < 32; i++) begin
        if (k == 5'(i)) ssid_next[8*i +: 8] = in_byte;
      end
      if (bad_byte) bad_next = 1'b1;
    end

    frame_len = {1'b0, pos_cur} + 7'd1;
    need_len  = {2'd0, MIN_FRAME_LEN} + {1'b0, tag_len_next};

    job.accept     = 1'b0;
    job.status     = ST_HIT;
    job.client     = client_next;
    job.ssid       = ssid_next;
    job.ssid_bytes = tag_len_next[5:0];
    job.rssi       = in_rssi;
    job.now_ms     = in_now;
    if (!in_mgmt) job.status = ST_NOT_MGMT;
    else if (frame_len < MIN_FRAME_LEN) job.status = ST_SHORT;
    else if (frame_ctrl_next[7:4] != SUBTYPE_PROBE) job.status = ST_SUBTYPE;
    else if (tag_id_next != 8'd0 || tag_len_next == 8'd0 ||
             tag_len_next > MAX_SSID_LEN || {2'd0, frame_len} < need_len)
      job.status = ST_NO_SSID;
    else if (bad_next) job.status = ST_BAD_CHAR;
    else job.accept = 1'b1;

    job_push = in_valid && in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reject_high_bytes <= 1'b1;
      pos        <= 6'd0;
      client     <= 48'd0;
      ssid       <= 256'd0;
      frame_ctrl <= 8'd0;
      tag_id     <= 8'd0;
      tag_len    <= 8'd0;
      bad        <= 1'b0;
    end else begin
      if (cfg_we) reject_high_bytes <= cfg_wdata;
      if (in_valid) begin
        client     <= client_next;
        ssid       <= ssid_next;
        frame_ctrl <= frame_ctrl_next;
        tag_id     <= tag_id_next;
        tag_len    <= tag_len_next;
        bad        <= bad_next;
        if (in_last) pos <= 6'd0;
        else if (pos_cur < POS_MAX) pos <= pos_cur + 6'd1;
        else pos <= POS_MAX;
      end
    end
  end

endmodule

[hdl/pst_queue.sv]
// Short job queue between the front and the back.
module pst_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pst_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output pst_pkg::job_t head
);
  import pst_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full)
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop && not_empty)
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      count <= count + CW'(push && !full) - CW'(pop && not_empty);
    end
  end

endmodule

[hdl/pst_back.sv]
// Table search, replacement and result register.
module pst_back #(
  parameter int TABLE_ENTRIES = pst_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  pst_pkg::job_t job,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [4:0]    out_index,
  output logic [31:0]   out_hits,
  output logic [31:0]   out_total,
  output logic [5:0]    out_count
);
  import pst_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic [47:0]  client_mem [TABLE_ENTRIES];
  logic [255:0] ssid_mem   [TABLE_ENTRIES];
  logic [5:0]   len_mem    [TABLE_ENTRIES];
  logic [31:0]  seen_mem   [TABLE_ENTRIES];
  logic [31:0]  hit_mem    [TABLE_ENTRIES];
  logic [7:0]   rssi_mem   [TABLE_ENTRIES];

  back_state_t  state, state_next;
  logic [CW-1:0] occ;
  logic [31:0]  probe_total;
  logic [CW-1:0] scan_addr;
  logic         cmp_v;
  logic [IW-1:0] cmp_slot;
  logic         found;
  logic [IW-1:0] match_slot;
  logic [31:0]  match_hits;
  logic [IW-1:0] min_slot;
  logic [31:0]  min_seen;

  logic [47:0]  rd_client;
  logic [255:0] rd_ssid;
  logic [5:0]   rd_len;
  logic [31:0]  rd_seen;
  logic [31:0]  rd_hits;

  logic         out_free;
  logic         reject_load;
  logic         start_scan;
  logic         write_go;
  logic         rd_en;
  logic         hit_now;
  logic [IW-1:0] wr_idx;
  logic [31:0]  wr_hits;
  status_t      wr_status;
  logic [CW-1:0] occ_after;
  logic [7:0]   idx_wide;
  logic [8:0]   occ_wide;
  logic [8:0]   occ_now_wide;

  assign out_free = !out_valid || out_ready;
  assign rd_en    = (state == B_SCAN) && (scan_addr < occ);
  assign hit_now  = cmp_v && (rd_client == job.client) && (rd_len == job.ssid_bytes) &&
                    (rd_ssid == job.ssid);

  always_comb begin
    state_next  = state;
    job_pop     = 1'b0;
    reject_load = 1'b0;
    start_scan  = 1'b0;
    write_go    = 1'b0;
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          if (!job.accept) begin
            if (out_free) begin
              reject_load = 1'b1;
              job_pop     = 1'b1;
            end
          end else begin
            start_scan = 1'b1;
            state_next = B_SCAN;
          end
        end
      end
      B_SCAN: begin
        if (scan_addr == occ && !cmp_v) state_next = B_WRITE;
      end
      B_WRITE: begin
        if (out_free) begin
          write_go   = 1'b1;
          job_pop    = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    if (found) begin
      wr_idx    = match_slot;
      wr_status = ST_HIT;
      wr_hits   = match_hits + 32'd1;
      occ_after = occ;
    end else if (occ < CW'(TABLE_ENTRIES)) begin
      wr_idx    = occ[IW-1:0];
      wr_status = ST_NEW;
      wr_hits   = 32'd1;
      occ_after = occ + CW'(1);
    end else begin
      wr_idx    = min_slot;
      wr_status = ST_EVICTED;
      wr_hits   = 32'd1;
      occ_after = occ;
    end
    idx_wide     = 8'(wr_idx);
    occ_wide     = 9'(occ_after);
    occ_now_wide = 9'(occ);
  end

  // Table memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (write_go) begin
      if (!found) begin
        client_mem[wr_idx] <= job.client;
        ssid_mem[wr_idx]   <= job.ssid;
        len_mem[wr_idx]    <= job.ssid_bytes;
      end
      seen_mem[wr_idx] <= job.now_ms;
      hit_mem[wr_idx]  <= wr_hits;
      rssi_mem[wr_idx] <= job.rssi;
    end
    if (rd_en) begin
      rd_client <= client_mem[scan_addr[IW-1:0]];
      rd_ssid   <= ssid_mem[scan_addr[IW-1:0]];
      rd_len    <= len_mem[scan_addr[IW-1:0]];
      rd_seen   <= seen_mem[scan_addr[IW-1:0]];
      rd_hits   <= hit_mem[scan_addr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      occ         <= '0;
      probe_total <= 32'd0;
      out_valid   <= 1'b0;
      cmp_v       <= 1'b0;
      scan_addr   <= '0;
      found       <= 1'b0;
    end else begin
      state <= state_next;
      if (start_scan) begin
        probe_total <= probe_total + 32'd1;
        scan_addr   <= '0;
        found       <= 1'b0;
        cmp_v       <= 1'b0;
      end else if (state == B_SCAN) begin
        cmp_v <= rd_en;
        if (rd_en) scan_addr <= scan_addr + CW'(1);
        if (hit_now && !found) found <= 1'b1;
      end
      if (write_go) occ <= occ_after;
      if (reject_load || write_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) cmp_slot <= scan_addr[IW-1:0];
    if (cmp_v) begin
      if (hit_now && !found) begin
        match_slot <= cmp_slot;
        match_hits <= rd_hits;
      end
      // strict compare keeps the lowest index on ties
      if (cmp_slot == '0 || rd_seen < min_seen) begin
        min_slot <= cmp_slot;
        min_seen <= rd_seen;
      end
    end
    if (reject_load) begin
      out_status <= job.status;
      out_index  <= 5'd0;
      out_hits   <= 32'd0;
      out_total  <= probe_total;
      out_count  <= occ_now_wide[5:0];
    end else if (write_go) begin
      out_status <= wr_status;
      out_index  <= idx_wide[4:0];
      out_hits   <= wr_hits;
      out_total  <= probe_total;
      out_count  <= occ_wide[5:0];
    end
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(TABLE_ENTRIES)) else $error("occupancy above table size");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_addr <= occ) else $error("scan ran past occupied slots");
  a_found_scan: assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE) && start_scan |=> !found && (state == B_SCAN))
    else $error("scan did not restart cleanly");
  a_load_once: assert property (@(posedge clk) disable iff (rst)
    (reject_load || write_go) |-> out_free) else $error("result overwritten");
`endif

endmodule

[hdl/probe_request_client_ssid_tracker.sv]
// Top level of the probe request client/SSID tracker.
// Frame bytes enter on the s_axis channel, one byte per request; tlast marks
// the final byte of a frame, at which the frame is judged. Every frame gives
// exactly one result on m_axis; other bytes give none.
// The front captures header, client MAC and SSID at one byte per cycle while
// the queue has room and hands a judged frame to a two-entry queue. The back
// searches the table one slot per cycle through the registered memory read
// port. A rejected frame passes from the queue straight to the output
// register; an accepted one first goes through the table search and the
// write state. The back takes one frame at a time.
// s_axis_tready drops only while the queue is full; the front keeps taking
// bytes while the back searches. A stalled m_axis holds its result in the
// output register; the back then waits and the queue fills behind it.
// Reset empties the table (no clearing pass), the counters and the queue,
// and sets reject_high_bytes to 1. cfg_we writes reject_high_bytes.
module probe_request_client_ssid_tracker #(
  parameter int TABLE_ENTRIES = pst_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // frame_byte[7:0], signal_strength[15:8], now_ms[47:16]
  input  logic [47:0] s_axis_tdata,
  // first_byte[0], is_management[1]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], entry_index[7:3], entry_hits[39:8], total_probes[71:40],
  // entry_count[77:72], zero[79:78]
  output logic [79:0] m_axis_tdata
);
  import pst_pkg::*;

  job_t        front_job;
  job_t        head_job;
  logic        push;
  logic        full;
  logic        pop;
  logic        not_empty;
  logic [2:0]  status;
  logic [4:0]  entry_index;
  logic [31:0] entry_hits;
  logic [31:0] total_probes;
  logic [5:0]  entry_count;

  assign s_axis_tready = !full;

  pst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_axis_tvalid && s_axis_tready),
    .in_byte  (s_axis_tdata[7:0]),
    .in_first (s_axis_tuser[0]),
    .in_last  (s_axis_tlast),
    .in_mgmt  (s_axis_tuser[1]),
    .in_rssi  (s_axis_tdata[15:8]),
    .in_now   (s_axis_tdata[47:16]),
    .job      (front_job),
    .job_push (push)
  );

  pst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .full     (full),
    .pop      (pop),
    .not_empty(not_empty),
    .head     (head_job)
  );

  pst_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (not_empty),
    .job       (head_job),
    .job_pop   (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_status(status),
    .out_index (entry_index),
    .out_hits  (entry_hits),
    .out_total (total_probes),
    .out_count (entry_count)
  );

  assign m_axis_tdata = {2'b00, entry_count, total_probes, entry_hits, entry_index, status};

endmodule
